>>> hdl/btw_pkg.sv
// ----------------------------------------------------------------------------
// btw_pkg: shared types, constants and helpers for balanced_ternary_weights
// Holds the field widths, parameter defaults, remainder codes, the state
// encoding and the radix-4 divide-by-three digit step.
// ----------------------------------------------------------------------------
package btw_pkg;

  localparam int WEIGHT_W        = 20;   // width of the weight field
  localparam int TERM_W          = 22;   // width of the signed term field
  localparam int WEIGHT_BITS_DEF = 20;
  localparam int MAX_DIGITS_DEF  = 14;

  // Remainder of a value modulo three, and what it means as a digit
  localparam logic [1:0] REM_ZERO  = 2'd0;  // digit 0
  localparam logic [1:0] REM_PLUS  = 2'd1;  // digit +1
  localparam logic [1:0] REM_MINUS = 2'd2;  // digit -1, raise quotient by one

  typedef enum logic [1:0] {
    ST_IDLE,   // wait for a weight
    ST_CONV,   // find digits, one divide pass per digit
    ST_NEG,    // emit negative terms, highest position first
    ST_POS     // emit positive terms, lowest position first
  } state_t;

  // Status from the divider back to the sequencer
  typedef struct packed {
    logic       done;  // quotient and remainder are ready this cycle
    logic [1:0] rem;   // value modulo three
  } div_res_t;

  // One radix-4 long-division step by three: t = {remainder, two dividend bits},
  // t is at most 11. Returns {quotient digit, new remainder}.
  function automatic logic [3:0] div3_step(input logic [3:0] t);
    logic [1:0] q;
    logic [3:0] r;
    if (t >= 4'd9) begin
      q = 2'd3;
    end else if (t >= 4'd6) begin
      q = 2'd2;
    end else if (t >= 4'd3) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    r = t - ({2'b00, q} + {1'b0, q, 1'b0});
    return {q, r[1:0]};
  endfunction

endpackage

>>> hdl/btw_div3.sv
// ----------------------------------------------------------------------------
// btw_div3: digit-serial divide by three
// Shifts the dividend through a register two bits per cycle, most significant
// first, and shifts the quotient digits in behind it. Reports the quotient and
// the remainder, registered, in the cycle after the last digit.
// ----------------------------------------------------------------------------
module btw_div3 #(
  parameter int W = btw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [W-1:0]        value,
  output logic [W-1:0]        quot,
  output btw_pkg::div_res_t   res
);
  import btw_pkg::*;

  localparam int DW = W + (W % 2);
  localparam int ND = DW / 2;
  localparam int CW = (ND > 1) ? $clog2(ND) : 1;

  logic [DW-1:0] sh_r, sh_nxt;
  logic [1:0]    rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [3:0]    step;

  assign step = div3_step({rem_r, sh_r[DW-1 -: 2]});

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = DW'(value);
      rem_nxt  = REM_ZERO;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift out two dividend bits, shift in one quotient digit
      sh_nxt  = DW'({sh_r, step[3:2]});
      rem_nxt = step[1:0];
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(ND - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot     = sh_r[W-1:0];
  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

>>> hdl/balanced_ternary_weights.sv
// ----------------------------------------------------------------------------
// balanced_ternary_weights: weight to balanced-ternary terms
// Converts one unsigned weight to balanced ternary and emits the signed
// powers of three of its non-zero digits in ascending numeric order.
// ----------------------------------------------------------------------------
// The block takes one weight at a time and returns its non-zero balanced-
// ternary digits as signed powers of three: first the negative terms (largest
// magnitude first), then the positive terms (smallest first); out_last marks
// the final beat, and a zero weight produces no beat at all. Each digit
// position takes one pass of the radix-4 divide-by-three unit; conversion
// stops once the remaining value is zero or MAX_DIGITS positions are done.
// Emission then scans the used positions downward for negative digits and
// upward for positive digits, one position a cycle while the output register
// is free, and ends with the last term; in_stall is high from acceptance
// until the last beat is loaded into the output register, or until conversion
// ends for a zero weight. Terms wider than 22 bits wrap, and digits above
// MAX_DIGITS are dropped.
module balanced_ternary_weights #(
  parameter int WEIGHT_BITS = btw_pkg::WEIGHT_BITS_DEF,
  parameter int MAX_DIGITS  = btw_pkg::MAX_DIGITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [btw_pkg::WEIGHT_W-1:0]       in_weight,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [btw_pkg::TERM_W-1:0]  out_term,
  output logic                               out_last
);
  import btw_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        di_r, di_nxt;      // digit position being found
  logic [IDX_W-1:0]        idx_r, idx_nxt;    // emission scan position
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;    // non-zero digits found / left
  logic [MAX_DIGITS-1:0]   neg_r, neg_nxt;
  logic [MAX_DIGITS-1:0]   pos_r, pos_nxt;
  logic [TERM_W-1:0]       p_r, p_nxt;        // 3^di, wrapped to term width
  logic [TERM_W-1:0]       pw_r [MAX_DIGITS];
  logic                    pw_we;

  logic                    out_valid_r, out_valid_nxt;
  logic [TERM_W-1:0]       out_term_r, out_term_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_acc;
  logic                    adv;
  logic                    div_start;
  logic [WEIGHT_BITS-1:0]  div_value;
  logic [WEIGHT_BITS-1:0]  div_quot;
  div_res_t                div_res;
  logic [WEIGHT_BITS-1:0]  w_next;
  logic                    step_done;
  logic                    stop;
  logic [CNT_W-1:0]        cnt_step;

  btw_div3 #(
    .W (WEIGHT_BITS)
  ) u_div3 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (div_value),
    .quot  (div_quot),
    .res   (div_res)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // The output register frees up when it is empty or its beat is taken.
  assign adv = !out_valid_r || !out_stall;

  // Remainder two means digit -1: the next value is the quotient plus one.
  assign w_next    = div_quot + WEIGHT_BITS'(div_res.rem == REM_MINUS);
  assign step_done = (state_r == ST_CONV) && div_res.done;
  assign stop      = (w_next == '0) || (di_r == IDX_W'(MAX_DIGITS - 1));
  assign cnt_step  = cnt_r + CNT_W'(div_res.rem != REM_ZERO);

  always_comb begin
    state_nxt     = state_r;
    di_nxt        = di_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    pos_nxt       = pos_r;
    p_nxt         = p_r;
    pw_we         = 1'b0;
    div_start     = 1'b0;
    div_value     = WEIGHT_BITS'(in_weight);
    out_valid_nxt = out_valid_r && out_stall;
    out_term_nxt  = out_term_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // load the masked weight and clear the digit record
          div_start = 1'b1;
          di_nxt    = '0;
          cnt_nxt   = '0;
          neg_nxt   = '0;
          pos_nxt   = '0;
          p_nxt     = TERM_W'(1);
          state_nxt = ST_CONV;
        end
      end

      ST_CONV: begin
        if (step_done) begin
          pw_we         = 1'b1;
          neg_nxt[di_r] = (div_res.rem == REM_MINUS);
          pos_nxt[di_r] = (div_res.rem == REM_PLUS);
          cnt_nxt       = cnt_step;
          if (stop) begin
            // last position found: start emission from the top
            idx_nxt   = di_r;
            state_nxt = (cnt_step == '0) ? ST_IDLE : ST_NEG;
          end else begin
            div_start = 1'b1;
            div_value = w_next;
            di_nxt    = di_r + IDX_W'(1);
            p_nxt     = TERM_W'({p_r, 1'b0}) + p_r;
          end
        end
      end

      ST_NEG: begin
        if (adv) begin
          if (neg_r[idx_r]) begin
            out_valid_nxt = 1'b1;
            out_term_nxt  = TERM_W'(0) - pw_r[idx_r];
            out_last_nxt  = (cnt_r == CNT_W'(1));
            cnt_nxt       = cnt_r - CNT_W'(1);
          end
          priority if (neg_r[idx_r] && cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else if (idx_r == '0) begin
            state_nxt = ST_POS;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end

      ST_POS: begin
        if (adv) begin
          if (pos_r[idx_r]) begin
            out_valid_nxt = 1'b1;
            out_term_nxt  = pw_r[idx_r];
            out_last_nxt  = (cnt_r == CNT_W'(1));
            cnt_nxt       = cnt_r - CNT_W'(1);
          end
          priority if (pos_r[idx_r] && cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else if (idx_r != di_r) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Power table: one entry written per digit step, read at the scan position.
  always_ff @(posedge clk) begin
    if (pw_we) begin
      pw_r[di_r] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    di_r       <= di_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    pos_r      <= pos_nxt;
    p_r        <= p_nxt;
    out_term_r <= out_term_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_term  = $signed(out_term_r);
  assign out_last  = out_last_r;

  // While emitting, at least one term is always still owed.
  a_emit_has_terms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NEG || state_r == ST_POS) |-> (cnt_r != '0))
    else $error("emission state with no terms left");

  // The divider reports only while a conversion is running.
  a_div_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_CONV))
    else $error("divider result outside conversion");

  // An accepted weight always starts a conversion.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CONV))
    else $error("accepted weight did not start conversion");

  // Every beat loaded with the last mark ends the item.
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (state_r == ST_NEG || state_r == ST_POS) && out_valid_nxt
     && out_last_nxt) |=> (state_r == ST_IDLE))
    else $error("last term loaded but item not finished");

endmodule
